/* src/bencode_delimiter_matcher_macros.svh */
// Assertion macros for the bencode delimiter matcher.
`ifndef BENCODE_DELIMITER_MATCHER_MACROS_SVH
`define BENCODE_DELIMITER_MATCHER_MACROS_SVH

`ifndef SYNTHESIS
`define BDM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define BDM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define BDM_ASSERT(lbl, prop, msg)
`define BDM_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* src/bdm_pkg.sv */
package bdm_pkg;

  localparam int unsigned FIELD_W = 24;

  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_L     = 8'h6C;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [1:0] ST_PAIR = 2'd0;
  localparam logic [1:0] ST_OK   = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [FIELD_W-1:0] open_pos;
    logic [FIELD_W-1:0] close_pos;
    logic [1:0]         status;
    logic               run_end;
  } out_t;

endpackage

/* src/bdm_ram.sv */
module bdm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* src/bencode_delimiter_matcher.sv */
// Channel | Dir | Handshake                | Word
// in      | in  | in_valid_i, in_ready_o   | bdm_pkg::in_t: in_byte, last_byte
// out     | out | out_valid_o, out_ready_i | bdm_pkg::out_t: open_pos, close_pos, status, run_end
//
// One byte is accepted per cycle while in_ready_o is high; a word passes the input register and the
// scan logic and is written to the eight-entry result queue in the cycle after acceptance, so its
// first result can leave the queue once it has been written.
// A byte yields at most two results, so a run of final bytes is limited by the output port.
// The open stack sits in one RAM; its top two entries are kept in registers.
// Reset clears all control state; stack entries are never cleared.
// Input is stalled while the queue might not hold the results of the byte in flight and of a new byte.
`include "bencode_delimiter_matcher_macros.svh"

module bencode_delimiter_matcher #(
  parameter int unsigned NEST_DEPTH = 64,
  parameter int unsigned POS_BITS   = 24
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  bdm_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output bdm_pkg::out_t out_data_o
);

  localparam int unsigned CntW   = $clog2(NEST_DEPTH + 1);
  localparam int unsigned AddrW  = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
  localparam int unsigned QDepth = 8;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned FW     = bdm_pkg::FIELD_W;

  typedef enum logic [1:0] {
    MODE_TOKEN,
    MODE_INT,
    MODE_LEN,
    MODE_PAYLOAD
  } mode_e;

  logic                stg_v_q;
  bdm_pkg::in_t        stg_q;

  logic [POS_BITS-1:0] pos_q, pos_d;
  mode_e               mode_q, mode_d;
  logic [POS_BITS-1:0] start_q, start_d;
  logic [POS_BITS-1:0] acc_q, acc_d;
  logic [POS_BITS-1:0] left_q, left_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [POS_BITS-1:0] top_q, top_d;
  logic [POS_BITS-1:0] nxt_q, nxt_d;
  logic                failed_q, failed_d;
  logic                byp_q;
  logic [POS_BITS-1:0] byp_data_q;

  logic                ram_we;
  logic [AddrW-1:0]    ram_waddr;
  logic [AddrW-1:0]    ram_raddr;
  logic [POS_BITS-1:0] ram_rdata;
  logic [POS_BITS-1:0] below;
  logic [CntW+1:0]     waddr_full;
  logic [CntW+1:0]     raddr_full;

  logic [7:0]          b;
  logic                digit;
  logic [3:0]          dval;
  logic [POS_BITS+3:0] len_next;
  logic [POS_BITS-1:0] left_dec;
  logic                pair_v;
  logic [POS_BITS-1:0] pair_open;
  logic                verdict_v;
  logic                ok;
  logic [FW+POS_BITS-1:0] open_ext;
  logic [FW+POS_BITS-1:0] close_ext;
  bdm_pkg::out_t       res0, res1;
  logic [1:0]          npush;

  bdm_pkg::out_t       q_mem_q [QDepth];
  logic [QPtrW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [QPtrW:0]      occ_q;
  logic                pop;
  logic [QPtrW+1:0]    room_need;

  assign b         = stg_q.in_byte;
  assign digit     = (b >= bdm_pkg::CH_ZERO) && (b <= bdm_pkg::CH_NINE);
  assign dval      = 4'(b - bdm_pkg::CH_ZERO);
  assign len_next  = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + (POS_BITS + 4)'(dval);
  assign left_dec  = left_q - POS_BITS'(1);
  assign below     = byp_q ? byp_data_q : ram_rdata;

  always_comb begin
    pos_d     = pos_q;
    mode_d    = mode_q;
    start_d   = start_q;
    acc_d     = acc_q;
    left_d    = left_q;
    cnt_d     = cnt_q;
    top_d     = top_q;
    nxt_d     = nxt_q;
    failed_d  = failed_q;
    ram_we    = 1'b0;
    pair_v    = 1'b0;
    pair_open = start_q;
    verdict_v = 1'b0;
    ok        = 1'b0;
    if (stg_v_q) begin
      pos_d = pos_q + POS_BITS'(1);
      if (!failed_q) begin
        unique case (mode_q)
          MODE_TOKEN: begin
            priority if (b == bdm_pkg::CH_E) begin
              if (cnt_q != '0) begin
                cnt_d     = cnt_q - CntW'(1);
                pair_v    = 1'b1;
                pair_open = top_q;
                top_d     = nxt_q;
                nxt_d     = below;
              end else begin
                failed_d = 1'b1;
              end
            end else if ((b == bdm_pkg::CH_L) || (b == bdm_pkg::CH_D)) begin
              if (cnt_q < CntW'(NEST_DEPTH)) begin
                cnt_d  = cnt_q + CntW'(1);
                top_d  = pos_q;
                nxt_d  = top_q;
                ram_we = (cnt_q >= CntW'(2));
              end else begin
                failed_d = 1'b1;
              end
            end else if (b == bdm_pkg::CH_I) begin
              start_d = pos_q;
              mode_d  = MODE_INT;
            end else if (digit) begin
              start_d = pos_q;
              acc_d   = POS_BITS'(dval);
              mode_d  = MODE_LEN;
            end else begin
              failed_d = 1'b1;
            end
          end
          MODE_INT: begin
            if (b == bdm_pkg::CH_E) begin
              pair_v = 1'b1;
              mode_d = MODE_TOKEN;
            end
          end
          MODE_LEN: begin
            priority if (digit) begin
              if (|len_next[POS_BITS+3:POS_BITS]) begin
                failed_d = 1'b1;
              end else begin
                acc_d = len_next[POS_BITS-1:0];
              end
            end else if (b == bdm_pkg::CH_COLON) begin
              if (acc_q == '0) begin
                pair_v = 1'b1;
                mode_d = MODE_TOKEN;
              end else begin
                left_d = acc_q;
                mode_d = MODE_PAYLOAD;
              end
            end else begin
              failed_d = 1'b1;
            end
          end
          MODE_PAYLOAD: begin
            left_d = left_dec;
            if (left_dec == '0) begin
              pair_v = 1'b1;
              mode_d = MODE_TOKEN;
            end
          end
          default: begin
            failed_d = 1'b1;
          end
        endcase
      end
      if (stg_q.last_byte) begin
        verdict_v = 1'b1;
        ok        = !failed_d && (mode_d == MODE_TOKEN) && (cnt_d == '0);
        pos_d     = '0;
        mode_d    = MODE_TOKEN;
        start_d   = '0;
        acc_d     = '0;
        left_d    = '0;
        cnt_d     = '0;
        failed_d  = 1'b0;
      end
    end
  end

  assign waddr_full = {2'b00, cnt_q} - (CntW + 2)'(2);
  assign raddr_full = {2'b00, cnt_d} - (CntW + 2)'(3);
  assign ram_waddr  = waddr_full[AddrW-1:0];
  assign ram_raddr  = raddr_full[AddrW-1:0];

  bdm_ram #(
    .WIDTH (POS_BITS),
    .DEPTH (NEST_DEPTH)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (nxt_q),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign open_ext  = {{FW{1'b0}}, pair_open};
  assign close_ext = {{FW{1'b0}}, pos_q};

  always_comb begin
    bdm_pkg::out_t pair_r;
    bdm_pkg::out_t verd_r;
    pair_r.open_pos  = open_ext[FW-1:0];
    pair_r.close_pos = close_ext[FW-1:0];
    pair_r.status    = bdm_pkg::ST_PAIR;
    pair_r.run_end   = 1'b0;
    verd_r.open_pos  = '0;
    verd_r.close_pos = '0;
    verd_r.status    = ok ? bdm_pkg::ST_OK : bdm_pkg::ST_BAD;
    verd_r.run_end   = 1'b1;
    res0  = pair_v ? pair_r : verd_r;
    res1  = verd_r;
    npush = 2'(pair_v) + 2'(verdict_v);
  end

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (occ_q != '0);
  assign out_data_o  = q_mem_q[rd_ptr_q];
  assign room_need   = {1'b0, occ_q} + {{QPtrW{1'b0}}, stg_v_q, 1'b0};
  assign in_ready_o  = (room_need <= (QPtrW + 2)'(QDepth - 2));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_v_q  <= 1'b0;
      pos_q    <= '0;
      mode_q   <= MODE_TOKEN;
      start_q  <= '0;
      acc_q    <= '0;
      left_q   <= '0;
      cnt_q    <= '0;
      failed_q <= 1'b0;
      byp_q    <= 1'b0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      occ_q    <= '0;
    end else begin
      stg_v_q  <= in_valid_i && in_ready_o;
      pos_q    <= pos_d;
      mode_q   <= mode_d;
      start_q  <= start_d;
      acc_q    <= acc_d;
      left_q   <= left_d;
      cnt_q    <= cnt_d;
      failed_q <= failed_d;
      byp_q    <= ram_we && (ram_waddr == ram_raddr);
      wr_ptr_q <= wr_ptr_q + QPtrW'(npush);
      rd_ptr_q <= rd_ptr_q + QPtrW'(pop);
      occ_q    <= occ_q + (QPtrW + 1)'(npush) - (QPtrW + 1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      stg_q <= in_data_i;
    end
    top_q      <= top_d;
    nxt_q      <= nxt_d;
    byp_data_q <= nxt_q;
    if (npush != 2'd0) begin
      q_mem_q[wr_ptr_q] <= res0;
    end
    if (npush == 2'd2) begin
      q_mem_q[wr_ptr_q + QPtrW'(1)] <= res1;
    end
  end

  `BDM_ASSERT(a_queue_bound, (occ_q <= (QPtrW + 1)'(QDepth)), "Result queue overfilled.")
  `BDM_ASSERT(a_stack_bound, (cnt_q <= CntW'(NEST_DEPTH)), "Open stack count beyond its depth.")
  `BDM_ASSERT(a_stage_fill, (in_valid_i && in_ready_o |=> stg_v_q), "Accepted word did not reach the scan stage.")
  `BDM_ASSERT(a_verdict_code, (out_valid_o |-> (out_data_o.run_end == (out_data_o.status != bdm_pkg::ST_PAIR))), "Verdict flag and status disagree.")
  `BDM_ASSERT_ALWAYS(a_reset_idle, (!rst_ni |=> (occ_q == '0)), "Result queue not empty in reset.")

endmodule

/* verif/tb_bencode_delimiter_matcher.sv */
module tb_bencode_delimiter_matcher;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NEST_DEPTH   = 64;
  localparam int unsigned POS_W        = bdm_pkg::FIELD_W;
  localparam int unsigned RANDOM_BYTES = 1300;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam logic [7:0]  CH_MINUS     = 8'h2D;
  localparam logic [7:0]  BYTE_JUNK    = 8'h78;

  typedef enum logic [1:0] {PH_TOKEN, PH_INT, PH_LEN, PH_BODY} phase_e;

  typedef struct packed {
    logic          [7:0] b;
    logic                last;
    logic                typed;
    bdm_pkg::out_t       word;
  } row_t;

  localparam bdm_pkg::out_t NO_WORD     = '0;
  localparam bdm_pkg::out_t VERDICT_OK  = '{open_pos: '0, close_pos: '0,
                                            status: bdm_pkg::ST_OK, run_end: 1'b1};
  localparam bdm_pkg::out_t VERDICT_BAD = '{open_pos: '0, close_pos: '0,
                                            status: bdm_pkg::ST_BAD, run_end: 1'b1};

  localparam int unsigned DIR_N = 26;
  localparam row_t DIR_ROWS [DIR_N] = '{
    '{bdm_pkg::CH_I, 1'b0, 1'b0, NO_WORD},
    '{bdm_pkg::CH_E, 1'b1, 1'b1, VERDICT_OK},
    '{bdm_pkg::CH_ZERO, 1'b0, 1'b0, NO_WORD},
    '{bdm_pkg::CH_COLON, 1'b1, 1'b1, VERDICT_OK},
    '{bdm_pkg::CH_L, 1'b0, 1'b0, NO_WORD},
    '{bdm_pkg::CH_E, 1'b1, 1'b1, VERDICT_OK},
    '{bdm_pkg::CH_E, 1'b1, 1'b1, VERDICT_BAD},
    '{8'hFF, 1'b1, 1'b1, VERDICT_BAD},
    '{8'h00, 1'b1, 1'b1, VERDICT_BAD},
    '{bdm_pkg::CH_ZERO + 8'd1, 1'b0, 1'b0, NO_WORD},
    '{BYTE_JUNK, 1'b1, 1'b1, VERDICT_BAD},
    '{bdm_pkg::CH_ZERO + 8'd1, 1'b0, 1'b0, NO_WORD},
    '{bdm_pkg::CH_ZERO + 8'd6, 1'b0, 1'b0, NO_WORD},
    '{bdm_pkg::CH_ZERO + 8'd7, 1'b0, 1'b0, NO_WORD},
    '{bdm_pkg::CH_ZERO + 8'd7, 1'b0, 1'b0, NO_WORD},
    '{bdm_pkg::CH_ZERO + 8'd7, 1'b0, 1'b0, NO_WORD},
    '{bdm_pkg::CH_ZERO + 8'd2, 1'b0, 1'b0, NO_WORD},
    '{bdm_pkg::CH_ZERO + 8'd1, 1'b0, 1'b0, NO_WORD},
    '{bdm_pkg::CH_ZERO + 8'd6, 1'b1, 1'b1, VERDICT_BAD},
    '{bdm_pkg::CH_L, 1'b1, 1'b1, VERDICT_BAD},
    '{bdm_pkg::CH_I, 1'b1, 1'b1, VERDICT_BAD},
    '{bdm_pkg::CH_ZERO + 8'd3, 1'b0, 1'b0, NO_WORD},
    '{bdm_pkg::CH_COLON, 1'b0, 1'b0, NO_WORD},
    '{8'h61, 1'b0, 1'b0, NO_WORD},
    '{8'h62, 1'b0, 1'b0, NO_WORD},
    '{8'h63, 1'b1, 1'b1, VERDICT_OK}
  };

  logic          clk       = 1'b0;
  logic          rst_n     = 1'b0;
  logic          in_valid  = 1'b0;
  logic          in_ready;
  bdm_pkg::in_t  in_word   = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  bdm_pkg::out_t out_word;

  bit          quiet       = 1'b0;
  int unsigned hold_left   = 0;
  int unsigned faults      = 0;
  int unsigned cycle_count = 0;

  logic [POS_W-1:0] byte_pos;
  phase_e           phase;
  logic [POS_W-1:0] tok_open;
  logic [POS_W-1:0] len_sum;
  logic [POS_W-1:0] body_left;
  logic [POS_W-1:0] nest_stack [NEST_DEPTH];
  int unsigned      nest_depth;
  bit               broken;

  bdm_pkg::out_t due_spans [$];
  logic [7:0]    run_bytes [$];

  bencode_delimiter_matcher u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_word)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (quiet) begin
      out_ready <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      hold_left <= $urandom_range(0, 14);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_spans
    bdm_pkg::out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (due_spans.size() == 0) begin
        $display("%0t: unexpected word open=%0d close=%0d status=%0d end=%0b", $time,
                 out_word.open_pos, out_word.close_pos, out_word.status, out_word.run_end);
        faults++;
      end else begin
        want = due_spans.pop_front();
        if (want.open_pos !== out_word.open_pos || want.close_pos !== out_word.close_pos ||
            want.status !== out_word.status || want.run_end !== out_word.run_end) begin
          $display("%0t: expected %0d/%0d/%0d/%0b, got %0d/%0d/%0d/%0b", $time,
                   want.open_pos, want.close_pos, want.status, want.run_end,
                   out_word.open_pos, out_word.close_pos, out_word.status, out_word.run_end);
          faults++;
        end
      end
    end
  end

  function automatic bdm_pkg::out_t mk_word(logic [POS_W-1:0] o, logic [POS_W-1:0] c,
                                            logic [1:0] s, logic r);
    bdm_pkg::out_t w;
    w.open_pos  = o;
    w.close_pos = c;
    w.status    = s;
    w.run_end   = r;
    return w;
  endfunction

  function automatic void expect_word(bdm_pkg::out_t w);
    due_spans.insert(due_spans.size(), w);
  endfunction

  function automatic void add_byte(logic [7:0] v);
    run_bytes.insert(run_bytes.size(), v);
  endfunction

  function automatic void clear_scan();
    byte_pos   = '0;
    phase      = PH_TOKEN;
    tok_open   = '0;
    len_sum    = '0;
    body_left  = '0;
    nest_depth = 0;
    broken     = 1'b0;
  endfunction

  function automatic void scan_byte(bdm_pkg::in_t w);
    logic [7:0]  b;
    logic        is_digit;
    logic [63:0] grown;
    b        = w.in_byte;
    is_digit = (b >= bdm_pkg::CH_ZERO) && (b <= bdm_pkg::CH_NINE);
    if (!broken) begin
      case (phase)
        PH_TOKEN: begin
          if (b == bdm_pkg::CH_E) begin
            if (nest_depth > 0) begin
              nest_depth--;
              expect_word(mk_word(nest_stack[nest_depth], byte_pos, bdm_pkg::ST_PAIR, 1'b0));
            end else begin
              broken = 1'b1;
            end
          end else if (b == bdm_pkg::CH_L || b == bdm_pkg::CH_D) begin
            if (nest_depth < NEST_DEPTH) begin
              nest_stack[nest_depth] = byte_pos;
              nest_depth++;
            end else begin
              broken = 1'b1;
            end
          end else if (b == bdm_pkg::CH_I) begin
            tok_open = byte_pos;
            phase    = PH_INT;
          end else if (is_digit) begin
            tok_open = byte_pos;
            len_sum  = POS_W'(b - bdm_pkg::CH_ZERO);
            phase    = PH_LEN;
          end else begin
            broken = 1'b1;
          end
        end
        PH_INT: begin
          if (b == bdm_pkg::CH_E) begin
            expect_word(mk_word(tok_open, byte_pos, bdm_pkg::ST_PAIR, 1'b0));
            phase = PH_TOKEN;
          end
        end
        PH_LEN: begin
          if (is_digit) begin
            grown = 64'(len_sum) * 64'd10 + 64'(b - bdm_pkg::CH_ZERO);
            if (grown > 64'({POS_W{1'b1}})) begin
              broken = 1'b1;
            end else begin
              len_sum = grown[POS_W-1:0];
            end
          end else if (b == bdm_pkg::CH_COLON) begin
            if (len_sum == '0) begin
              expect_word(mk_word(tok_open, byte_pos, bdm_pkg::ST_PAIR, 1'b0));
              phase = PH_TOKEN;
            end else begin
              body_left = len_sum;
              phase     = PH_BODY;
            end
          end else begin
            broken = 1'b1;
          end
        end
        default: begin
          body_left = body_left - 1'b1;
          if (body_left == '0) begin
            expect_word(mk_word(tok_open, byte_pos, bdm_pkg::ST_PAIR, 1'b0));
            phase = PH_TOKEN;
          end
        end
      endcase
    end
    byte_pos = byte_pos + 1'b1;
    if (w.last_byte) begin
      expect_word(mk_word('0, '0,
          (!broken && phase == PH_TOKEN && nest_depth == 0) ? bdm_pkg::ST_OK : bdm_pkg::ST_BAD,
          1'b1));
      clear_scan();
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last, input logic typed,
                           input bdm_pkg::out_t word);
    bdm_pkg::in_t w;
    w.in_byte   = b;
    w.last_byte = last;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 14)) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (!in_ready);
    scan_byte(w);
    if (typed) due_spans[$] = word;
  endtask

  function automatic void push_number(longint unsigned v);
    string digits;
    digits = $sformatf("%0d", v);
    if ($urandom_range(0, 7) == 0) add_byte(bdm_pkg::CH_ZERO);
    for (int i = 0; i < digits.len(); i++) add_byte(digits[i]);
  endfunction

  function automatic void add_scalar();
    int unsigned len;
    if ($urandom_range(0, 1)) begin
      add_byte(bdm_pkg::CH_I);
      if ($urandom_range(0, 3) == 0) add_byte(CH_MINUS);
      repeat ($urandom_range(0, 4)) add_byte(bdm_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
      add_byte(bdm_pkg::CH_E);
    end else begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 14) : $urandom_range(0, 5);
      push_number(len);
      add_byte(bdm_pkg::CH_COLON);
      repeat (len) add_byte(8'($urandom_range(0, 255)));
    end
  endfunction

  function automatic void grow_tree(int unsigned steps, int unsigned max_nest);
    int unsigned lvl;
    int unsigned c;
    lvl = 0;
    repeat (steps) begin
      c = $urandom_range(0, 2);
      if (c == 0 && lvl < max_nest) begin
        add_byte($urandom_range(0, 1) ? bdm_pkg::CH_L : bdm_pkg::CH_D);
        lvl++;
      end else if (c == 1 && lvl > 0) begin
        add_byte(bdm_pkg::CH_E);
        lvl--;
      end else begin
        add_scalar();
      end
    end
    repeat (lvl) add_byte(bdm_pkg::CH_E);
  endfunction

  function automatic void build_run();
    int unsigned pick;
    int unsigned opens;
    run_bytes.delete();
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      grow_tree($urandom_range(2, 24), $urandom_range(1, 6));
    end else if (pick < 65) begin
      opens = NEST_DEPTH + (pick % 2);
      repeat (opens) add_byte($urandom_range(0, 1) ? bdm_pkg::CH_L : bdm_pkg::CH_D);
      add_scalar();
      repeat (opens) add_byte(bdm_pkg::CH_E);
    end else if (pick < 88) begin
      grow_tree($urandom_range(2, 16), $urandom_range(1, 4));
      case ($urandom_range(0, 4))
        0: run_bytes[$urandom_range(0, run_bytes.size() - 1)] = 8'($urandom_range(0, 255));
        1: run_bytes = run_bytes[0:$urandom_range(0, run_bytes.size() - 1)];
        2: add_byte(bdm_pkg::CH_E);
        3: begin
          push_number(64'd16777216 + $urandom_range(0, 1000));
          add_byte(bdm_pkg::CH_COLON);
        end
        default: begin
          push_number(64'd16777215);
          add_byte(bdm_pkg::CH_COLON);
          repeat ($urandom_range(0, 6)) add_byte(8'($urandom_range(0, 255)));
        end
      endcase
    end else begin
      repeat ($urandom_range(1, 8)) add_byte(8'($urandom_range(0, 255)));
    end
  endfunction

  initial begin : stimulus
    int unsigned sent;
    bit          paused;
    sent   = 0;
    paused = 1'b0;
    clear_scan();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_N; i++) begin
      send_byte(DIR_ROWS[i].b, DIR_ROWS[i].last, DIR_ROWS[i].typed, DIR_ROWS[i].word);
    end

    while (sent < RANDOM_BYTES) begin
      build_run();
      if (!paused && sent >= RANDOM_BYTES / 2) begin
        paused = 1'b1;
        @(negedge clk);
        in_valid <= 1'b0;
        while (due_spans.size() != 0) @(posedge clk);
      end
      for (int k = 0; k < run_bytes.size(); k++) begin
        send_byte(run_bytes[k], k == run_bytes.size() - 1, 1'b0, NO_WORD);
      end
      sent += run_bytes.size();
      quiet = (sent + 150 >= RANDOM_BYTES);
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (due_spans.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (faults == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
